// ----- src/fmcp_pkg.sv -----
// ----------------------------------------------------------------------------
// fmcp_pkg
// shared types and constants of the fuse map text cell parser
// ----------------------------------------------------------------------------
package fmcp_pkg;

  localparam int ROW_W    = 11;
  localparam int COL_W    = 8;
  localparam int ADDR_W   = 19;
  localparam int CODE_W   = 21;
  localparam int CHAR_W   = 8;
  localparam int WIDTH_W  = 8;

  localparam logic [WIDTH_W-1:0] ROW_WIDTH_RESET = 8'd50;

  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
  localparam logic [CHAR_W-1:0] CH_A_LOW = 8'h61;
  localparam logic [CHAR_W-1:0] CH_Z_LOW = 8'h7A;
  localparam logic [CHAR_W-1:0] CH_UNDER = 8'h5F;

  localparam logic signed [CODE_W-1:0] CODE_ZERO  = -21'sd1;
  localparam logic signed [CODE_W-1:0] CODE_ONE   = -21'sd2;
  localparam logic signed [CODE_W-1:0] CODE_SPARE = -21'sd3;
  localparam logic signed [CODE_W-1:0] CODE_SEC   = -21'sd10;
  localparam logic signed [CODE_W-1:0] CODE_DONE  = -21'sd12;
  localparam logic signed [CODE_W-1:0] CODE_USER  = -21'sd44;

  // blank mode codes
  localparam logic [1:0] BLANK_FILLED = 2'd0;
  localparam logic [1:0] BLANK_AFTER  = 2'd1;
  localparam logic [1:0] BLANK_LINE   = 2'd2;

  // keyword slots, padded with zero bytes that never match a letter
  localparam int WORD_SLOTS = 8;
  localparam int WORD_IDX_W = 3;
  localparam int NUM_WORDS  = 4;

  localparam int W_SPARE = 0;
  localparam int W_SEC   = 1;
  localparam int W_DONE  = 2;
  localparam int W_USER  = 3;

  localparam logic [CHAR_W-1:0] WORD_SPARE [WORD_SLOTS] =
    '{8'h73, 8'h70, 8'h61, 8'h72, 8'h65, 8'h00, 8'h00, 8'h00};
  localparam logic [CHAR_W-1:0] WORD_SEC [WORD_SLOTS] =
    '{8'h73, 8'h65, 8'h63, 8'h5F, 8'h00, 8'h00, 8'h00, 8'h00};
  localparam logic [CHAR_W-1:0] WORD_DONE [WORD_SLOTS] =
    '{8'h64, 8'h6F, 8'h6E, 8'h65, 8'h5F, 8'h00, 8'h00, 8'h00};
  localparam logic [CHAR_W-1:0] WORD_USER [WORD_SLOTS] =
    '{8'h75, 8'h73, 8'h65, 8'h72, 8'h5F, 8'h00, 8'h00, 8'h00};

  typedef struct packed {
    logic                     done;
    logic [ROW_W-1:0]         row;
    logic [COL_W-1:0]         column;
    logic signed [CODE_W-1:0] code;
  } fmcp_cell_t;

endpackage

// ----- src/fuse_map_text_cell_parser_top.sv -----
// ----------------------------------------------------------------------------
// fuse_map_text_cell_parser_top
// parses tab-separated map text into one coded word per cell
// ----------------------------------------------------------------------------
// One character is taken every cycle. Each character is held in an input
// register, decoded against the cell state in the next cycle, and a tab or
// newline loads the result register, which drives the cell word outputs. Only
// a tab or newline that meets a held result word waits; digits, letters and
// ignored bytes always pass. row_width is written through cfg_wr_en /
// cfg_wr_data and takes effect on the next cell.
module fuse_map_text_cell_parser_top #(
  parameter int LETTER_DEPTH = 8,
  parameter int ACC_BITS     = 20
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [fmcp_pkg::WIDTH_W-1:0]         cfg_wr_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [fmcp_pkg::CHAR_W-1:0]          in_char_in,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [fmcp_pkg::ROW_W-1:0]           out_cell_row,
  output logic [fmcp_pkg::COL_W-1:0]           out_cell_column,
  output logic [fmcp_pkg::ADDR_W-1:0]          out_cell_address,
  output logic signed [fmcp_pkg::CODE_W-1:0]   out_cell_code
);
  import fmcp_pkg::*;

  logic [WIDTH_W-1:0]       row_width_r;
  logic                     in_valid_r;
  logic [CHAR_W-1:0]        in_char_r;
  logic                     out_valid_r;
  logic [ROW_W-1:0]         out_row_r;
  logic [COL_W-1:0]         out_col_r;
  logic [ADDR_W-1:0]        out_addr_r;
  logic signed [CODE_W-1:0] out_code_r;

  fmcp_cell_t               cell_info;
  logic                     out_free, proc;
  logic [ADDR_W:0]          addr_sum;

  fmcp_cell_track #(
    .LETTER_DEPTH (LETTER_DEPTH),
    .ACC_BITS     (ACC_BITS)
  ) u_track (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (proc),
    .char_in   (in_char_r),
    .cell_info (cell_info)
  );

  assign out_free = !out_valid_r || out_ready;
  assign proc     = in_valid_r && (!cell_info.done || out_free);
  assign in_ready = !in_valid_r || proc;

  assign addr_sum = (ADDR_W+1)'(cell_info.row) * (ADDR_W+1)'(row_width_r)
                  + (ADDR_W+1)'(cell_info.column);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r <= ROW_WIDTH_RESET;
    end else if (cfg_wr_en) begin
      row_width_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_char_r <= in_char_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc && cell_info.done) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && cell_info.done) begin
      out_row_r  <= cell_info.row;
      out_col_r  <= cell_info.column;
      out_addr_r <= addr_sum[ADDR_W-1:0];
      out_code_r <= cell_info.code;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_cell_row     = out_row_r;
  assign out_cell_column  = out_col_r;
  assign out_cell_address = out_addr_r;
  assign out_cell_code    = out_code_r;

endmodule

// ----- src/fmcp_cell_track.sv -----
// ----------------------------------------------------------------------------
// fmcp_cell_track
// per-character cell state: number, keyword prefix flags, blank mode,
// row and column; gives the finished cell for a tab or newline
// ----------------------------------------------------------------------------
module fmcp_cell_track #(
  parameter int LETTER_DEPTH = 8,
  parameter int ACC_BITS     = 20
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  logic [fmcp_pkg::CHAR_W-1:0]   char_in,
  output fmcp_pkg::fmcp_cell_t          cell_info
);
  import fmcp_pkg::*;

  localparam int CNT_W = $clog2(LETTER_DEPTH + 1);

  logic [ACC_BITS-1:0]  acc_r,   acc_nxt;
  logic [1:0]           blank_r, blank_nxt;
  logic [CNT_W-1:0]     cnt_r,   cnt_nxt;
  logic [NUM_WORDS-1:0] match_r, match_nxt;
  logic [ROW_W-1:0]     row_r,   row_nxt;
  logic [COL_W-1:0]     col_r,   col_nxt;

  logic                 is_digit, is_letter, is_term;
  logic [ACC_BITS+3:0]  prod;
  logic [WORD_IDX_W-1:0] widx;
  logic                 slot_ok;
  logic signed [CODE_W-1:0] acc_code, code;

  always_comb begin
    is_digit  = char_in inside {[CH_0:CH_9]};
    is_letter = (char_in inside {[CH_A_LOW:CH_Z_LOW]}) || (char_in == CH_UNDER);
    is_term   = (char_in == CH_TAB) || (char_in == CH_LF);
  end

  // acc * 10 + digit, saturating
  assign prod = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0}
              + (ACC_BITS+4)'(char_in - CH_0);

  assign widx    = cnt_r[WORD_IDX_W-1:0];
  assign slot_ok = {1'b0, cnt_r} < (CNT_W+1)'(WORD_SLOTS);

  // cell code
  always_comb begin
    acc_code = CODE_W'(acc_r);
    if (blank_r == BLANK_LINE) begin
      code = CODE_ZERO;
    end else if (blank_r == BLANK_AFTER) begin
      code = CODE_ONE;
    end else begin
      code = acc_code;
    end
    if (cnt_r != '0) begin
      if (match_r[W_SPARE]) begin
        code = CODE_SPARE;
      end else if (match_r[W_SEC]) begin
        code = code + CODE_SEC;
      end else if (match_r[W_DONE]) begin
        code = code + CODE_DONE;
      end else if (match_r[W_USER]) begin
        code = code + CODE_USER;
      end
    end
  end

  assign cell_info.done   = is_term;
  assign cell_info.row    = row_r;
  assign cell_info.column = col_r;
  assign cell_info.code   = code;

  always_comb begin
    acc_nxt   = acc_r;
    blank_nxt = blank_r;
    cnt_nxt   = cnt_r;
    match_nxt = match_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    if (is_digit) begin
      acc_nxt   = (|prod[ACC_BITS+3:ACC_BITS]) ? {ACC_BITS{1'b1}} : prod[ACC_BITS-1:0];
      blank_nxt = BLANK_FILLED;
    end else if (is_letter) begin
      if (cnt_r < CNT_W'(LETTER_DEPTH)) begin
        cnt_nxt          = cnt_r + 1'b1;
        match_nxt[W_SPARE] = match_r[W_SPARE] && slot_ok && (char_in == WORD_SPARE[widx]);
        match_nxt[W_SEC]   = match_r[W_SEC]   && slot_ok && (char_in == WORD_SEC[widx]);
        match_nxt[W_DONE]  = match_r[W_DONE]  && slot_ok && (char_in == WORD_DONE[widx]);
        match_nxt[W_USER]  = match_r[W_USER]  && slot_ok && (char_in == WORD_USER[widx]);
      end
      blank_nxt = BLANK_FILLED;
    end else if (is_term) begin
      if (blank_r != BLANK_LINE && blank_r != BLANK_AFTER) begin
        blank_nxt = BLANK_AFTER;
      end
      acc_nxt   = '0;
      cnt_nxt   = '0;
      match_nxt = '1;
      col_nxt   = col_r + 1'b1;
      if (char_in == CH_LF) begin
        col_nxt   = '0;
        row_nxt   = row_r + 1'b1;
        blank_nxt = BLANK_LINE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      blank_r <= BLANK_LINE;
      cnt_r   <= '0;
      match_r <= '1;
      row_r   <= '0;
      col_r   <= '0;
    end else if (step) begin
      acc_r   <= acc_nxt;
      blank_r <= blank_nxt;
      cnt_r   <= cnt_nxt;
      match_r <= match_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
    end
  end

endmodule

// ----- tb/fuse_map_text_cell_parser_top_test.sv -----
// ----------------------------------------------------------------------------
// fuse_map_text_cell_parser_top_test
// checks the cell words of the map text parser against a local prediction
// ----------------------------------------------------------------------------
// Characters go in over a valid/ready channel with random gaps. Each accepted
// character updates a local copy of the parser state. Every tab or newline
// queues the expected cell word, and each word that comes out is checked
// field by field. A directed part covers blank cells, keyword prefixes,
// saturation and ignored bytes. Random map text runs under several row
// widths, a stretch without idling and a pause until all words are back. A
// final part wraps the column counter.
module fuse_map_text_cell_parser_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import fmcp_pkg::*;

  localparam int LETTER_DEPTH = 8;
  localparam int ACC_BITS = 20;
  localparam longint ACC_MAX = (longint'(1) << ACC_BITS) - 1;
  localparam logic [CHAR_W-1:0] CH_CR = 8'h0D;

  typedef struct {
    logic [ROW_W-1:0]         row;
    logic [COL_W-1:0]         column;
    logic [ADDR_W-1:0]        address;
    logic signed [CODE_W-1:0] code;
  } cell_word_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       cfg_wr_en = 1'b0;
  logic [WIDTH_W-1:0]         cfg_wr_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [CHAR_W-1:0]          in_char_in = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [ROW_W-1:0]           out_cell_row;
  logic [COL_W-1:0]           out_cell_column;
  logic [ADDR_W-1:0]          out_cell_address;
  logic signed [CODE_W-1:0]   out_cell_code;

  // parser state as predicted
  logic [WIDTH_W-1:0]  row_width_now = ROW_WIDTH_RESET;
  logic [ACC_BITS-1:0] number_now = '0;
  logic [1:0]          blank_now = BLANK_LINE;
  int                  letters_held = 0;
  logic [CHAR_W-1:0]   letters_now [LETTER_DEPTH];
  logic [ROW_W-1:0]    row_now = '0;
  logic [COL_W-1:0]    column_now = '0;

  cell_word_t cell_words_due [$];
  int         errors = 0;
  int         chars_sent = 0;
  bit         steady = 1'b0;
  string      keywords [4] = '{"spare", "sec_", "done_", "user_"};

  fuse_map_text_cell_parser_top u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_char_in       (in_char_in),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_cell_row     (out_cell_row),
    .out_cell_column  (out_cell_column),
    .out_cell_address (out_cell_address),
    .out_cell_code    (out_cell_code)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 6);
  end

  function automatic bit letters_prefix_of(input string word);
    if (letters_held > word.len()) return 1'b0;
    for (int i = 0; i < letters_held; i++) begin
      if (letters_now[i] != word[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic parse_char(input logic [CHAR_W-1:0] ch);
    cell_word_t word;
    longint     code;
    longint     next_number;
    int         address;
    if (ch >= CH_0 && ch <= CH_9) begin
      next_number = longint'(number_now) * 10 + longint'(ch - CH_0);
      number_now = (next_number > ACC_MAX) ? ACC_MAX[ACC_BITS-1:0]
                                           : next_number[ACC_BITS-1:0];
      blank_now = BLANK_FILLED;
    end else if (ch == CH_UNDER || (ch >= CH_A_LOW && ch <= CH_Z_LOW)) begin
      if (letters_held < LETTER_DEPTH) begin
        letters_now[letters_held] = ch;
        letters_held++;
      end
      blank_now = BLANK_FILLED;
    end else if (ch == CH_TAB || ch == CH_LF) begin
      code = longint'(number_now);
      if (blank_now == BLANK_LINE) begin
        code = CODE_ZERO;
      end else if (blank_now == BLANK_AFTER) begin
        code = CODE_ONE;
      end else begin
        blank_now = BLANK_AFTER;
      end
      if (letters_held > 0) begin
        if (letters_prefix_of(keywords[0])) code = CODE_SPARE;
        else if (letters_prefix_of(keywords[1])) code = code + CODE_SEC;
        else if (letters_prefix_of(keywords[2])) code = code + CODE_DONE;
        else if (letters_prefix_of(keywords[3])) code = code + CODE_USER;
        letters_held = 0;
      end
      address = int'(row_now) * int'(row_width_now) + int'(column_now);
      word.row = row_now;
      word.column = column_now;
      word.address = address[ADDR_W-1:0];
      word.code = code[CODE_W-1:0];
      cell_words_due.push_back(word);
      number_now = '0;
      column_now = column_now + 1'b1;
      if (ch == CH_LF) begin
        column_now = '0;
        row_now = row_now + 1'b1;
        blank_now = BLANK_LINE;
      end
    end
  endtask

  task automatic send_char(input logic [CHAR_W-1:0] ch);
    if (!steady && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_char_in <= ch;
    do @(posedge clk); while (!in_ready);
    parse_char(ch);
    chars_sent++;
  endtask

  task automatic send_text(input string text);
    for (int i = 0; i < text.len(); i++) send_char(text[i]);
  endtask

  task automatic wait_for_cells();
    in_valid <= 1'b0;
    while (cell_words_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_row_width(input logic [WIDTH_W-1:0] width);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= width;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    row_width_now = width;
  endtask

  task automatic send_digits();
    int n;
    n = ($urandom_range(7) == 0) ? $urandom_range(8, 5) : $urandom_range(4, 1);
    repeat (n) send_char(CHAR_W'(CH_0 + $urandom_range(9)));
  endtask

  task automatic send_letters();
    int r;
    repeat ($urandom_range(10, 1)) begin
      r = $urandom_range(26);
      send_char((r == 26) ? CH_UNDER : CHAR_W'(CH_A_LOW + r));
    end
  endtask

  task automatic send_random_cell();
    string word;
    int    n;
    case ($urandom_range(9))
      0: ;
      1, 2, 3: send_digits();
      4, 5: begin
        word = keywords[$urandom_range(3)];
        n = $urandom_range(word.len(), 1);
        if ($urandom_range(1)) send_digits();
        for (int i = 0; i < n; i++) send_char(word[i]);
        if ($urandom_range(3) == 0) send_letters();
        if ($urandom_range(2) == 0) send_digits();
      end
      6: send_letters();
      7: begin
        send_digits();
        send_letters();
      end
      default: send_char(CHAR_W'($urandom_range(255)));
    endcase
  endtask

  task automatic send_random_line();
    int cells;
    cells = $urandom_range(12, 1);
    for (int i = 0; i < cells; i++) begin
      send_random_cell();
      if (i == cells - 1) begin
        if ($urandom_range(3) == 0) send_char(CH_CR);
        send_char(CH_LF);
      end else begin
        send_char(CH_TAB);
      end
    end
  endtask

  task automatic send_random_text(input int n_chars);
    int stop;
    stop = chars_sent + n_chars;
    while (chars_sent < stop) send_random_line();
  endtask

  task automatic test_directed_cells();
    // blank at line start, number, blank after a filled cell
    send_text("\t5\t\t\n");
    send_text("s\t");
    send_text("se2\t");
    send_text("d\r\n");
    send_text("#u\t");
    // accumulator saturation
    send_text("9999999\t");
    send_char(8'hFF);
    send_char(8'h00);
    send_char(CH_LF);
  endtask

  task automatic test_row_width_extremes();
    wait_for_cells();
    write_row_width(8'd1);
    send_random_text(100);
    wait_for_cells();
    write_row_width(8'd255);
    send_random_text(100);
  endtask

  task automatic test_steady_stream();
    wait_for_cells();
    steady = 1'b1;
    write_row_width(WIDTH_W'($urandom_range(255, 1)));
    send_random_text(110);
    wait_for_cells();
    steady = 1'b0;
  endtask

  task automatic test_sender_pause();
    wait_for_cells();
    write_row_width(ROW_WIDTH_RESET);
    send_random_text(55);
    wait_for_cells();
    send_random_text(50);
  endtask

  task automatic test_counter_wrap();
    wait_for_cells();
    write_row_width(8'd255);
    send_text("user_9\t");
    repeat (257) send_char(CH_TAB);
    send_char(CH_LF);
    send_text("1048575\n");
  endtask

  always @(posedge clk) begin
    cell_word_t due;
    if (rst_n && out_valid && out_ready) begin
      if (cell_words_due.size() == 0) begin
        errors++;
        $display("%0t unexpected word: row %0d column %0d address %0d code %0d",
                 $time, out_cell_row, out_cell_column, out_cell_address, out_cell_code);
      end else begin
        due = cell_words_due.pop_front();
        if (out_cell_row !== due.row) begin
          errors++;
          $display("%0t cell_row: expected %0d, actual %0d", $time, due.row, out_cell_row);
        end
        if (out_cell_column !== due.column) begin
          errors++;
          $display("%0t cell_column: expected %0d, actual %0d",
                   $time, due.column, out_cell_column);
        end
        if (out_cell_address !== due.address) begin
          errors++;
          $display("%0t cell_address: expected %0d, actual %0d",
                   $time, due.address, out_cell_address);
        end
        if (out_cell_code !== due.code) begin
          errors++;
          $display("%0t cell_code: expected %0d, actual %0d", $time, due.code, out_cell_code);
        end
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_cells();
    test_row_width_extremes();
    test_steady_stream();
    test_sender_pause();
    test_counter_wrap();
    wait_for_cells();
    repeat (8) @(posedge clk);
    if (cell_words_due.size() != 0) begin
      errors++;
      $display("%0t words still expected: %0d", $time, cell_words_due.size());
    end
    if (errors == 0) begin
      $display("fuse_map_text_cell_parser_top_test: done, clean");
    end else begin
      $display("fuse_map_text_cell_parser_top_test: done, errors");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("%0t timeout", $time);
    $display("fuse_map_text_cell_parser_top_test: done, errors");
    $finish;
  end

endmodule
